>>> src/x86_subset_execute_unit_top_macros.svh
// ----------------------------------------------------------------------------
// x86 subset execute unit assertion macros
// Shared property forms for the checker of the execute unit.
// ----------------------------------------------------------------------------
`ifndef X86_SUBSET_EXECUTE_UNIT_TOP_MACROS_SVH
`define X86_SUBSET_EXECUTE_UNIT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XSEU_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("execute unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define XSEU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("execute unit assertion failed");

`endif

>>> src/xseu_pkg.sv
// ----------------------------------------------------------------------------
// x86 subset execute unit package
// Opcodes, operand kinds, the request and commit types and an address helper.
// ----------------------------------------------------------------------------
package xseu_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [4:0] OP_ADDL  = 5'd0;
    localparam logic [4:0] OP_ANDL  = 5'd1;
    localparam logic [4:0] OP_LEAVE = 5'd2;
    localparam logic [4:0] OP_MOVL  = 5'd3;
    localparam logic [4:0] OP_PUSHL = 5'd4;
    localparam logic [4:0] OP_RET   = 5'd5;
    localparam logic [4:0] OP_SUBL  = 5'd6;
    localparam logic [4:0] OP_CMPL  = 5'd7;
    localparam logic [4:0] OP_INCL  = 5'd8;
    localparam logic [4:0] OP_JG    = 5'd9;
    localparam logic [4:0] OP_JLE   = 5'd10;
    localparam logic [4:0] OP_JMP   = 5'd11;
    localparam logic [4:0] OP_LEAL  = 5'd12;
    localparam logic [4:0] OP_CALL  = 5'd13;
    localparam logic [4:0] OP_SALL  = 5'd14;
    localparam logic [4:0] OP_IMULL = 5'd15;
    localparam logic [4:0] OP_DECL  = 5'd16;

    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_MEM = 2'd2;
    localparam logic       DST_MEM = 1'b1;

    localparam logic [2:0] SP_REG = 3'd4;
    localparam logic [2:0] BP_REG = 3'd5;

    typedef logic [MEM_AW-1:0] waddr_t;

    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  src_kind;
        logic [2:0]  src_reg;
        logic [31:0] src_value;
        logic        dst_kind;
        logic [2:0]  dst_reg;
        logic [13:0] dst_addr;
        logic [31:0] lea_disp;
        logic [2:0]  lea_base;
        logic [31:0] next_ip;
    } item_t;

    typedef struct packed {
        logic [31:0] new_ip;
        logic        sf;
        logic        zf;
        logic        wrote;
        logic [31:0] res;
        logic        bad;
        logic        mem_we;
        waddr_t      mem_addr;
        logic        reg_we;
        logic [2:0]  reg_addr;
        logic        sp_we;
        logic [31:0] sp_wdata;
    } commit_t;

    function automatic waddr_t word_index(input logic [31:0] byte_addr);
        return byte_addr[MEM_AW+1:2];
    endfunction

endpackage

>>> src/xseu_regfile.sv
// ----------------------------------------------------------------------------
// x86 subset execute unit register file
// Eight 32-bit registers and the SF/ZF flags, updated when a request commits.
// ----------------------------------------------------------------------------
module xseu_regfile import xseu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    input  commit_t     cm,
    input  logic [2:0]  rd_src,
    input  logic [2:0]  rd_dst,
    input  logic [2:0]  rd_lb,
    output logic [31:0] src_val,
    output logic [31:0] dst_val,
    output logic [31:0] lb_val,
    output logic [31:0] sp_val,
    output logic [31:0] bp_val,
    output logic        sf,
    output logic        zf
);

    logic [31:0] rf_reg [8];
    logic        sf_reg;
    logic        zf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                rf_reg[i] <= '0;
            end
            sf_reg <= 1'b0;
            zf_reg <= 1'b0;
        end else if (commit) begin
            if (cm.reg_we) begin
                rf_reg[cm.reg_addr] <= cm.res;
            end
            if (cm.sp_we) begin
                rf_reg[SP_REG] <= cm.sp_wdata;
            end
            sf_reg <= cm.sf;
            zf_reg <= cm.zf;
        end
    end

    assign src_val = rf_reg[rd_src];
    assign dst_val = rf_reg[rd_dst];
    assign lb_val  = rf_reg[rd_lb];
    assign sp_val  = rf_reg[SP_REG];
    assign bp_val  = rf_reg[BP_REG];
    assign sf      = sf_reg;
    assign zf      = zf_reg;

endmodule

>>> src/xseu_exec.sv
// ----------------------------------------------------------------------------
// x86 subset execute unit datapath
// Selects the operands, executes one instruction and forms its commit.
// ----------------------------------------------------------------------------
module xseu_exec import xseu_pkg::*; (
    input  item_t       item,
    input  logic [31:0] rf_src,
    input  logic [31:0] rf_dst,
    input  logic [31:0] rf_lb,
    input  logic [31:0] rf_sp,
    input  logic [31:0] rf_bp,
    input  logic        sf_in,
    input  logic        zf_in,
    input  logic [31:0] mem_a,
    input  logic [31:0] mem_b,
    output commit_t     cm
);

    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] prod;
    logic [31:0] sp_dec;
    logic [31:0] res;
    logic [31:0] flag_val;
    logic        set_f;
    logic        to_dst;
    logic        to_src;
    logic        wrote;

    assign src    = (item.src_kind == SRC_REG) ? rf_src :
                    (item.src_kind == SRC_MEM) ? mem_a : item.src_value;
    assign dst    = (item.dst_kind == DST_MEM) ? mem_b : rf_dst;
    assign prod   = dst * src;
    assign sp_dec = rf_sp - 32'd4;

    always_comb begin
        cm       = '0;
        cm.new_ip = item.next_ip;
        res      = '0;
        flag_val = '0;
        set_f    = 1'b0;
        to_dst   = 1'b0;
        to_src   = 1'b0;
        wrote    = 1'b0;
        unique case (item.op)
            OP_ADDL: begin
                res = dst + src;
                set_f = 1'b1;
                to_dst = 1'b1;
            end
            OP_ANDL: begin
                res = dst & src;
                set_f = 1'b1;
                to_dst = 1'b1;
            end
            OP_LEAVE: begin
                res = mem_a;
                cm.reg_we = 1'b1;
                cm.reg_addr = BP_REG;
                cm.sp_we = 1'b1;
                cm.sp_wdata = rf_bp + 32'd4;
                wrote = 1'b1;
            end
            OP_MOVL: begin
                res = src;
                to_dst = 1'b1;
            end
            OP_PUSHL: begin
                res = src;
                cm.sp_we = 1'b1;
                cm.sp_wdata = sp_dec;
                cm.mem_we = 1'b1;
                cm.mem_addr = word_index(sp_dec);
                wrote = 1'b1;
            end
            OP_RET: begin
                cm.new_ip = mem_a;
                cm.sp_we = 1'b1;
                cm.sp_wdata = rf_sp + 32'd4;
            end
            OP_SUBL: begin
                res = dst - src;
                set_f = 1'b1;
                to_dst = 1'b1;
            end
            OP_CMPL: begin
                set_f = 1'b1;
            end
            OP_INCL: begin
                res = src + 32'd1;
                set_f = 1'b1;
                to_src = 1'b1;
            end
            OP_JG: begin
                if (!sf_in && !zf_in) begin
                    cm.new_ip = src;
                end
            end
            OP_JLE: begin
                if (sf_in || zf_in) begin
                    cm.new_ip = src;
                end
            end
            OP_JMP: begin
                cm.new_ip = src;
            end
            OP_LEAL: begin
                res = item.lea_disp + rf_lb;
                to_dst = 1'b1;
            end
            OP_CALL: begin
                res = item.next_ip;
                cm.new_ip = src;
                cm.sp_we = 1'b1;
                cm.sp_wdata = sp_dec;
                cm.mem_we = 1'b1;
                cm.mem_addr = word_index(sp_dec);
                wrote = 1'b1;
            end
            OP_SALL: begin
                res = dst << src[4:0];
                set_f = 1'b1;
                to_dst = 1'b1;
            end
            OP_IMULL: begin
                res = prod;
                set_f = 1'b1;
                to_dst = 1'b1;
            end
            OP_DECL: begin
                res = src - 32'd1;
                set_f = 1'b1;
                to_src = 1'b1;
            end
            default: begin
                cm.bad = 1'b1;
            end
        endcase

        flag_val = (item.op == OP_CMPL) ? (dst - src) : res;
        cm.sf = set_f ? flag_val[31] : sf_in;
        cm.zf = set_f ? (flag_val == 32'd0) : zf_in;

        if (to_dst) begin
            wrote = 1'b1;
            if (item.dst_kind == DST_MEM) begin
                cm.mem_we = 1'b1;
                cm.mem_addr = word_index({18'd0, item.dst_addr});
            end else begin
                cm.reg_we = 1'b1;
                cm.reg_addr = item.dst_reg;
            end
        end
        if (to_src) begin
            if (item.src_kind == SRC_REG) begin
                wrote = 1'b1;
                cm.reg_we = 1'b1;
                cm.reg_addr = item.src_reg;
            end else if (item.src_kind == SRC_MEM) begin
                wrote = 1'b1;
                cm.mem_we = 1'b1;
                cm.mem_addr = word_index(item.src_value);
            end
        end

        cm.wrote = wrote;
        cm.res   = wrote ? res : 32'd0;
    end

endmodule

>>> src/x86_subset_execute_unit_top.sv
// ----------------------------------------------------------------------------
// x86 subset execute unit
// Executes one decoded instruction of a 17-opcode 32-bit x86 subset per
// request against eight registers, SF/ZF and a word-addressed data memory.
//
// Channel  Direction  Payload
// s_       in         instruction request (tdata fields, tuser operand kinds)
// m_       out        new IP, flags, destination write, bad opcode
//
// A request is accepted and its data memory words are read at that edge; it
// executes and writes back as it advances to the output, raising m_tvalid.
// One request per cycle is taken while the output is not stalled; a pushl,
// call, ret or leave behind an esp or ebp write waits until it has committed.
// Reset clears the registers and flags; the data memory is not cleared.
// While m_tready is low, one more request is taken into the execute stage.
// ----------------------------------------------------------------------------
module x86_subset_execute_unit_top import xseu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, src_reg, src_value, dst_reg, dst_addr, lea_disp, lea_base, next_ip
    input  logic [127:0] s_tdata,
    // src_kind, dst_kind
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_ip, sign_flag, zero_flag, wrote_dest, dest_result, bad_opcode
    output logic [71:0]  m_tdata
);

    item_t       in_item;
    item_t       p1_item_reg;
    logic        p1_valid_reg;
    logic        p1_valid_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [71:0] m_data_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        fwd_a_reg;
    logic        fwd_b_reg;
    logic [31:0] fwd_data_reg;
    logic [31:0] dmem [MEM_WORDS];

    commit_t     cm;
    logic        advance;
    logic        accept;
    logic        mem_we;
    logic        in_stack;
    logic        p1_stk_wr;
    waddr_t      addr_a;
    waddr_t      addr_b;
    logic [31:0] rf_src;
    logic [31:0] rf_dst;
    logic [31:0] rf_lb;
    logic [31:0] rf_sp;
    logic [31:0] rf_bp;
    logic        sf;
    logic        zf;
    logic [31:0] mem_a;
    logic [31:0] mem_b;

    assign in_item.op        = s_tdata[4:0];
    assign in_item.src_kind  = s_tuser[1:0];
    assign in_item.src_reg   = s_tdata[7:5];
    assign in_item.src_value = s_tdata[39:8];
    assign in_item.dst_kind  = s_tuser[2];
    assign in_item.dst_reg   = s_tdata[42:40];
    assign in_item.dst_addr  = s_tdata[56:43];
    assign in_item.lea_disp  = s_tdata[88:57];
    assign in_item.lea_base  = s_tdata[91:89];
    assign in_item.next_ip   = s_tdata[123:92];

    always_comb begin
        unique case (in_item.op) inside
            OP_LEAVE, OP_PUSHL, OP_RET, OP_CALL: in_stack = 1'b1;
            default:                             in_stack = 1'b0;
        endcase
    end

    assign p1_stk_wr = cm.sp_we ||
                       (cm.reg_we && (cm.reg_addr == SP_REG || cm.reg_addr == BP_REG));
    assign advance   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = aresetn && (!p1_valid_reg || advance) &&
                       !(p1_valid_reg && p1_stk_wr && in_stack);
    assign accept    = s_tvalid && s_tready;
    assign mem_we    = advance && cm.mem_we;

    assign addr_a = (in_item.op == OP_LEAVE) ? word_index(rf_bp) :
                    (in_item.op == OP_RET)   ? word_index(rf_sp) :
                                               word_index(in_item.src_value);
    assign addr_b = word_index({18'd0, in_item.dst_addr});

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dmem[cm.mem_addr] <= cm.res;
        end
        if (accept) begin
            rd_a_reg <= dmem[addr_a];
            rd_b_reg <= dmem[addr_b];
            fwd_a_reg <= mem_we && (cm.mem_addr == addr_a);
            fwd_b_reg <= mem_we && (cm.mem_addr == addr_b);
            fwd_data_reg <= cm.res;
            p1_item_reg <= in_item;
        end
    end

    assign mem_a = fwd_a_reg ? fwd_data_reg : rd_a_reg;
    assign mem_b = fwd_b_reg ? fwd_data_reg : rd_b_reg;

    xseu_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .cm      (cm),
        .rd_src  (p1_item_reg.src_reg),
        .rd_dst  (p1_item_reg.dst_reg),
        .rd_lb   (p1_item_reg.lea_base),
        .src_val (rf_src),
        .dst_val (rf_dst),
        .lb_val  (rf_lb),
        .sp_val  (rf_sp),
        .bp_val  (rf_bp),
        .sf      (sf),
        .zf      (zf)
    );

    xseu_exec u_exec (
        .item   (p1_item_reg),
        .rf_src (rf_src),
        .rf_dst (rf_dst),
        .rf_lb  (rf_lb),
        .rf_sp  (rf_sp),
        .rf_bp  (rf_bp),
        .sf_in  (sf),
        .zf_in  (zf),
        .mem_a  (mem_a),
        .mem_b  (mem_b),
        .cm     (cm)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {4'd0, cm.bad, cm.res, cm.wrote, cm.zf, cm.sf, cm.new_ip};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> src/xseu_checker.sv
// ----------------------------------------------------------------------------
// x86 subset execute unit checker
// Port-level properties of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "x86_subset_execute_unit_top_macros.svh"

module xseu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A stalled result must not change.
    `XSEU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A bad opcode never writes a destination.
    `XSEU_ASSERT_IMPLY(a_bad_no_write, aclk, aresetn, m_tvalid && m_tdata[67], !m_tdata[34] && (m_tdata[66:35] == 32'd0))

    // With the output stalled, at most one further request is held inside.
    `XSEU_ASSERT_NEXT(a_two_deep, aclk, aresetn, m_tvalid && !m_tready && s_tvalid && s_tready, m_tready || !s_tready)

    // A rising result has passed the execute-stage and output registers.
    `XSEU_ASSERT_IMPLY(a_rise_after_req, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind x86_subset_execute_unit_top xseu_checker u_xseu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/x86_subset_execute_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86 subset execute unit testbench
// Sends decoded instructions into the execute unit and predicts each result
// from an in-bench copy of the registers, flags and data memory. Memory is
// seeded through stack pushes, and directed cases cover flag edges, masked
// shift counts, immediate operands of incl/decl, stack frames and bad
// opcodes. Random programs follow, under three idling patterns on the two
// channels.
// ----------------------------------------------------------------------------
module x86_subset_execute_unit_top_tb import xseu_pkg::*; ();

    localparam logic [1:0] SRC_IMM     = 2'd1;
    localparam logic [1:0] SRC_IMM_ALT = 2'd3;
    localparam logic       DST_GPR     = 1'b0;
    localparam logic [4:0] OP_FIRST_BAD = 5'd17;
    localparam logic [4:0] OP_LAST_BAD  = 5'd31;
    localparam logic [2:0] EAX = 3'd0;
    localparam logic [2:0] ECX = 3'd1;
    localparam logic [2:0] EDX = 3'd2;
    localparam logic [2:0] EBX = 3'd3;
    localparam logic [2:0] ESI = 3'd6;
    localparam logic [31:0] STACK_STEP = 32'd4;

    typedef struct packed {
        logic [31:0] new_ip;
        logic        sf;
        logic        zf;
        logic        wrote;
        logic [31:0] res;
        logic        bad;
    } outcome_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    int send_gap_pct   = 10;
    int sink_stall_pct = 76;
    int error_count    = 0;

    logic [31:0] gpr [8];
    logic        flag_sf;
    logic        flag_zf;
    logic [31:0] mem_word  [MEM_WORDS];
    bit          mem_known [MEM_WORDS];
    waddr_t      known_slots [$];
    outcome_t    pending_results [$];

    x86_subset_execute_unit_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic waddr_t mem_slot(input logic [31:0] byte_addr);
        return waddr_t'((byte_addr >> 2) % MEM_WORDS);
    endfunction

    function automatic void store_word(input logic [31:0] byte_addr, input logic [31:0] value);
        waddr_t slot;
        slot = mem_slot(byte_addr);
        mem_word[slot] = value;
        if (!mem_known[slot]) begin
            mem_known[slot] = 1'b1;
            known_slots.push_back(slot);
        end
    endfunction

    function automatic void update_flags(input logic [31:0] value);
        flag_sf = value[31];
        flag_zf = (value == 32'd0);
    endfunction

    // Applies one instruction to the bench copy of the machine state and
    // returns what the unit must report for it.
    function automatic outcome_t execute_insn(input item_t insn);
        outcome_t    o;
        logic [31:0] src_val;
        logic [31:0] dst_val;
        logic [31:0] ip;
        logic [31:0] res;
        logic [31:0] sp;
        logic        to_dst;
        logic        to_src;
        logic        wrote;
        logic        bad;
        if (insn.src_kind == SRC_REG)
            src_val = gpr[insn.src_reg];
        else if (insn.src_kind == SRC_MEM)
            src_val = mem_word[mem_slot(insn.src_value)];
        else
            src_val = insn.src_value;
        dst_val = (insn.dst_kind == DST_MEM) ? mem_word[mem_slot({18'd0, insn.dst_addr})]
                                             : gpr[insn.dst_reg];
        ip = insn.next_ip;
        res = 32'd0;
        to_dst = 1'b0;
        to_src = 1'b0;
        wrote = 1'b0;
        bad = 1'b0;
        case (insn.op)
            OP_ADDL: begin
                res = dst_val + src_val;
                update_flags(res);
                to_dst = 1'b1;
            end
            OP_ANDL: begin
                res = dst_val & src_val;
                update_flags(res);
                to_dst = 1'b1;
            end
            OP_LEAVE: begin
                sp = gpr[BP_REG];
                res = mem_word[mem_slot(sp)];
                gpr[BP_REG] = res;
                gpr[SP_REG] = sp + STACK_STEP;
                wrote = 1'b1;
            end
            OP_MOVL: begin
                res = src_val;
                to_dst = 1'b1;
            end
            OP_PUSHL: begin
                sp = gpr[SP_REG] - STACK_STEP;
                gpr[SP_REG] = sp;
                store_word(sp, src_val);
                res = src_val;
                wrote = 1'b1;
            end
            OP_RET: begin
                sp = gpr[SP_REG];
                ip = mem_word[mem_slot(sp)];
                gpr[SP_REG] = sp + STACK_STEP;
            end
            OP_SUBL: begin
                res = dst_val - src_val;
                update_flags(res);
                to_dst = 1'b1;
            end
            OP_CMPL: update_flags(dst_val - src_val);
            OP_INCL: begin
                res = src_val + 32'd1;
                update_flags(res);
                to_src = 1'b1;
            end
            OP_JG: if (!flag_sf && !flag_zf) ip = src_val;
            OP_JLE: if (flag_sf || flag_zf) ip = src_val;
            OP_JMP: ip = src_val;
            OP_LEAL: begin
                res = insn.lea_disp + gpr[insn.lea_base];
                to_dst = 1'b1;
            end
            OP_CALL: begin
                sp = gpr[SP_REG] - STACK_STEP;
                gpr[SP_REG] = sp;
                store_word(sp, insn.next_ip);
                res = insn.next_ip;
                ip = src_val;
                wrote = 1'b1;
            end
            OP_SALL: begin
                res = dst_val << src_val[4:0];
                update_flags(res);
                to_dst = 1'b1;
            end
            OP_IMULL: begin
                res = dst_val * src_val;
                update_flags(res);
                to_dst = 1'b1;
            end
            OP_DECL: begin
                res = src_val - 32'd1;
                update_flags(res);
                to_src = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        if (to_dst) begin
            if (insn.dst_kind == DST_MEM)
                store_word({18'd0, insn.dst_addr}, res);
            else
                gpr[insn.dst_reg] = res;
            wrote = 1'b1;
        end
        if (to_src) begin
            if (insn.src_kind == SRC_REG) begin
                gpr[insn.src_reg] = res;
                wrote = 1'b1;
            end else if (insn.src_kind == SRC_MEM) begin
                store_word(insn.src_value, res);
                wrote = 1'b1;
            end
        end
        o.new_ip = ip;
        o.sf = flag_sf;
        o.zf = flag_zf;
        o.wrote = wrote;
        o.res = wrote ? res : 32'd0;
        o.bad = bad;
        return o;
    endfunction

    function automatic waddr_t pick_known_slot();
        return known_slots[$urandom_range(0, known_slots.size() - 1)];
    endfunction

    // Memory words never written are not to be read: a ret or leave that
    // reads one becomes a pushl and a memory operand goes to a written word.
    function automatic item_t make_safe(input item_t raw);
        item_t insn;
        insn = raw;
        if (insn.op == OP_RET && !mem_known[mem_slot(gpr[SP_REG])])
            insn.op = OP_PUSHL;
        if (insn.op == OP_LEAVE && !mem_known[mem_slot(gpr[BP_REG])])
            insn.op = OP_PUSHL;
        if (insn.src_kind == SRC_MEM && !mem_known[mem_slot(insn.src_value)])
            insn.src_value[MEM_AW+1:2] = pick_known_slot();
        if (insn.dst_kind == DST_MEM && !mem_known[mem_slot({18'd0, insn.dst_addr})])
            insn.dst_addr[MEM_AW+1:2] = pick_known_slot();
        return insn;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t make_insn(input logic [4:0] op, input logic [1:0] sk,
                                        input logic [2:0] sr, input logic [31:0] sv,
                                        input logic dk, input logic [2:0] dr,
                                        input logic [13:0] da);
        item_t insn;
        insn.op = op;
        insn.src_kind = sk;
        insn.src_reg = sr;
        insn.src_value = sv;
        insn.dst_kind = dk;
        insn.dst_reg = dr;
        insn.dst_addr = da;
        insn.lea_disp = $urandom;
        insn.lea_base = 3'($urandom_range(0, 7));
        insn.next_ip = $urandom;
        return insn;
    endfunction

    function automatic item_t random_insn();
        item_t insn;
        if ($urandom_range(0, 99) < 6)
            insn.op = 5'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD));
        else
            insn.op = 5'($urandom_range(OP_ADDL, OP_DECL));
        insn.src_kind = 2'($urandom_range(0, 3));
        insn.src_reg = 3'($urandom_range(0, 7));
        insn.src_value = random_word();
        insn.dst_kind = 1'($urandom_range(0, 1));
        insn.dst_reg = 3'($urandom_range(0, 7));
        insn.dst_addr = 14'($urandom);
        insn.lea_disp = random_word();
        insn.lea_base = 3'($urandom_range(0, 7));
        insn.next_ip = $urandom;
        return insn;
    endfunction

    task automatic send_insn(input item_t raw);
        item_t insn;
        insn = make_safe(raw);
        pending_results.push_back(execute_insn(insn));
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, insn.next_ip, insn.lea_base, insn.lea_disp, insn.dst_addr,
                     insn.dst_reg, insn.src_value, insn.src_reg, insn.op};
        s_tuser  <= {insn.dst_kind, insn.src_kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_results
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.new_ip = m_tdata[31:0];
            got.sf     = m_tdata[32];
            got.zf     = m_tdata[33];
            got.wrote  = m_tdata[34];
            got.res    = m_tdata[66:35];
            got.bad    = m_tdata[67];
            if (pending_results.size() == 0) begin
                if (error_count < 10)
                    $display("%0t: result with no request outstanding: ip=%h res=%h",
                             $realtime, got.new_ip, got.res);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.new_ip !== want.new_ip || got.sf !== want.sf || got.zf !== want.zf ||
                    got.wrote !== want.wrote || got.res !== want.res || got.bad !== want.bad) begin
                    if (error_count < 10)
                        $display({"%0t: mismatch: expected ip=%h sf=%b zf=%b wr=%b res=%h ",
                                  "bad=%b, got ip=%h sf=%b zf=%b wr=%b res=%h bad=%b"},
                                 $realtime, want.new_ip, want.sf, want.zf, want.wrote,
                                 want.res, want.bad, got.new_ip, got.sf, got.zf, got.wrote,
                                 got.res, got.bad);
                    error_count++;
                end
            end
        end
    end

    // Flags come out of reset clear, so jg is taken and jle is not.
    task automatic test_reset_flags();
        send_insn(make_insn(OP_JG, SRC_IMM, EAX, $urandom, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_JLE, SRC_IMM, EAX, $urandom, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_CMPL, SRC_REG, EAX, 32'd0, DST_GPR, ECX, 14'd0));
    endtask

    // Each word is written by pointing esp just above it and pushing.
    task automatic test_memory_seed();
        int unsigned seed_words [$];
        seed_words = '{0, 1, 2, 3, MEM_WORDS - 4, MEM_WORDS - 3, MEM_WORDS - 2, MEM_WORDS - 1};
        for (int b = 0; b < MEM_AW; b++) begin
            seed_words.push_back(1 << b);
            seed_words.push_back((MEM_WORDS - 1) ^ (1 << b));
        end
        repeat (6) seed_words.push_back($urandom_range(0, MEM_WORDS - 1));
        foreach (seed_words[i]) begin
            send_insn(make_insn(OP_MOVL, SRC_IMM, EAX, (seed_words[i] + 1) * STACK_STEP,
                                DST_GPR, SP_REG, 14'd0));
            send_insn(make_insn(OP_PUSHL, ($urandom_range(0, 1) != 0) ? SRC_IMM : SRC_IMM_ALT,
                                EAX, random_word(), DST_GPR, EAX, 14'd0));
        end
    endtask

    task automatic test_directed_ops();
        item_t insn;
        send_insn(make_insn(OP_MOVL, SRC_IMM, EAX, 32'h7FFF_FFFF, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_ADDL, SRC_IMM, EAX, 32'd1, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_ADDL, SRC_IMM_ALT, EAX, 32'h8000_0000, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_ANDL, SRC_REG, EAX, 32'd0, DST_MEM, EAX, 14'h3FFF));
        send_insn(make_insn(OP_SUBL, SRC_IMM, EAX, 32'd1, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_CMPL, SRC_IMM, EAX, 32'hFFFF_FFFF, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_JLE, SRC_IMM, EAX, $urandom, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_JG, SRC_IMM, EAX, $urandom, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_IMULL, SRC_REG, EAX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_MOVL, SRC_IMM, EAX, 32'h1234_5678, DST_GPR, ECX, 14'd0));
        send_insn(make_insn(OP_IMULL, SRC_IMM, EAX, 32'h8765_4321, DST_GPR, ECX, 14'd0));
        // A count of 33 shifts by one once masked to five bits.
        send_insn(make_insn(OP_SALL, SRC_IMM, EAX, 32'd33, DST_GPR, ECX, 14'd0));
        send_insn(make_insn(OP_SALL, SRC_IMM, EAX, 32'd31, DST_GPR, EAX, 14'd0));
        // Immediate operands of incl and decl set the flags and write nothing.
        send_insn(make_insn(OP_INCL, SRC_IMM, EAX, 32'h7FFF_FFFF, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_DECL, SRC_IMM_ALT, EAX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_INCL, SRC_MEM, EAX, 32'hFFFF_FFFC, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_DECL, SRC_REG, EDX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_MOVL, SRC_MEM, EAX, 32'd4, DST_GPR, EBX, 14'd0));
        insn = make_insn(OP_LEAL, SRC_IMM, EAX, 32'd0, DST_GPR, ESI, 14'd0);
        insn.lea_disp = 32'h8000_0000;
        insn.lea_base = EAX;
        send_insn(insn);
        send_insn(make_insn(OP_JMP, SRC_REG, EDX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_CALL, SRC_IMM, EAX, $urandom, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_PUSHL, SRC_REG, BP_REG, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_MOVL, SRC_REG, SP_REG, 32'd0, DST_GPR, BP_REG, 14'd0));
        send_insn(make_insn(OP_PUSHL, SRC_IMM, EAX, 32'hFFFF_FFFF, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_LEAVE, SRC_IMM, EAX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_RET, SRC_IMM, EAX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_FIRST_BAD, SRC_REG, EAX, 32'd0, DST_GPR, EAX, 14'd0));
        send_insn(make_insn(OP_LAST_BAD, SRC_MEM, EAX, 32'd0, DST_MEM, EAX, 14'd0));
        drain_results();
    endtask

    // Mostly single random instructions, with call/frame/leave/ret sequences
    // mixed in so that returns find a real return address on the stack.
    task automatic test_random_program(input int count, input int gap_pct, input int stall_pct);
        item_t insn;
        int    sent;
        int    body;
        send_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 12) begin
                send_insn(make_insn(OP_CALL, SRC_IMM, EAX, $urandom, DST_GPR, EAX, 14'd0));
                send_insn(make_insn(OP_PUSHL, SRC_REG, BP_REG, 32'd0, DST_GPR, EAX, 14'd0));
                send_insn(make_insn(OP_MOVL, SRC_REG, SP_REG, 32'd0, DST_GPR, BP_REG, 14'd0));
                body = $urandom_range(1, 4);
                repeat (body) begin
                    insn = random_insn();
                    if (insn.op == OP_LEAVE || insn.op == OP_RET)
                        insn.op = OP_MOVL;
                    if (insn.dst_reg == SP_REG || insn.dst_reg == BP_REG)
                        insn.dst_reg[1] = 1'b1;
                    if ((insn.op == OP_INCL || insn.op == OP_DECL) &&
                        (insn.src_reg == SP_REG || insn.src_reg == BP_REG))
                        insn.src_reg[1] = 1'b1;
                    send_insn(insn);
                end
                send_insn(make_insn(OP_LEAVE, SRC_IMM, EAX, 32'd0, DST_GPR, EAX, 14'd0));
                send_insn(make_insn(OP_RET, SRC_IMM, EAX, 32'd0, DST_GPR, EAX, 14'd0));
                sent += body + 5;
            end else begin
                send_insn(random_insn());
                sent++;
            end
        end
        drain_results();
    endtask

    initial begin
        foreach (gpr[i]) gpr[i] = 32'd0;
        flag_sf = 1'b0;
        flag_zf = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_flags();
        test_memory_seed();
        test_directed_ops();
        test_random_program(215, 10, 76);
        test_random_program(215, 76, 10);
        test_random_program(215, 0, 0);
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("x86_subset_execute_unit_top test passed");
        else
            $display("x86_subset_execute_unit_top test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("x86_subset_execute_unit_top test failed");
        $finish;
    end

endmodule
